// ===== src/pidl_pkg.sv =====
// package for the positional insert/delete list
// holds the default capacity, field widths, operation and status codes
// no dependencies
`timescale 1ns / 1ps

package pidl_pkg;

   // default number of list slots
   localparam int DEFAULT_CAPACITY = 16;

   // fixed field widths
   localparam int VALUE_W = 32;
   localparam int POS_W   = 5;
   localparam int COUNT_W = 5;

   // operation codes
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

// ===== src/pidl_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// used as the entry store of the list; no dependencies
`timescale 1ns / 1ps

module pidl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/positional_insert_delete_list.sv =====
// Positional insert/delete list: an ordered list of up to CAPACITY signed 32-bit
// entries held in one ram, addressed by 1-based position. An insert at position p
// (1 to count+1) moves entries p..count up one slot and stores the value; a remove
// at p (1 to count) returns the entry and moves later entries down. Each item gives
// one transfer on the rsp channel: status (done, position out of range, list full),
// the removed value (zero unless a remove succeeded) and the new count. The ram has
// one read and one write port, so an accepted item moves one entry per cycle in
// the shift state; an insert then writes the new value into the opened slot, and
// a refused item skips both. The result waits for the rsp register while the rsp
// side stalls with an earlier result still held. req_stall stays high while an
// item is being worked on; a finished result waits in the rsp register while the
// next item is taken. No clearing pass is needed after reset.
// depends on pidl_pkg and pidl_ram
`timescale 1ns / 1ps

module positional_insert_delete_list #(
   parameter int CAPACITY = pidl_pkg::DEFAULT_CAPACITY
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_operation,
   input  logic [pidl_pkg::POS_W-1:0]         req_position,
   input  logic signed [pidl_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic signed [pidl_pkg::VALUE_W-1:0] rsp_removed_value,
   output logic [pidl_pkg::COUNT_W-1:0]       rsp_count
);

   import pidl_pkg::*;

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SHIFT = 4'b0010,
      S_FINAL = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   op_type                    op_ff, op_in;
   logic [AW-1:0]             pos_idx_ff, pos_idx_in;
   logic [VALUE_W-1:0]        value_ff, value_in;
   status_type                status_ff, status_in;
   logic [VALUE_W-1:0]        removed_ff, removed_in;
   logic [AW-1:0]             addr_ff, addr_in;
   logic [CW-1:0]             left_ff, left_in;
   logic                      pend_ff, pend_in;
   logic                      pend_cap_ff, pend_cap_in;
   logic [AW-1:0]             pend_addr_ff, pend_addr_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff;
   logic [VALUE_W-1:0]        rsp_removed_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_load;

   logic                      mem_rd_en;
   logic [AW-1:0]             mem_rd_addr;
   logic                      mem_wr_en;
   logic [AW-1:0]             mem_wr_addr;
   logic [VALUE_W-1:0]        mem_wr_data;
   logic [VALUE_W-1:0]        mem_rd_data;

   logic [CMPW-1:0]           pos_x;
   logic [CMPW-1:0]           cnt_x;
   logic                      ins_ok;
   logic                      rem_ok;
   logic                      full;

   // entry store
   pidl_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   // position checks against the current count
   assign pos_x  = CMPW'(req_position);
   assign cnt_x  = CMPW'(count_ff);
   assign ins_ok = (req_position != '0) && (pos_x <= cnt_x + CMPW'(1));
   assign rem_ok = (req_position != '0) && (pos_x <= cnt_x);
   assign full   = (count_ff == CW'(CAPACITY));

   assign req_stall = (state_ff != S_IDLE);

   // sequencer: decode, shift one entry per cycle, final write, result
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      pos_idx_in   = pos_idx_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      removed_in   = removed_ff;
      addr_in      = addr_ff;
      left_in      = left_ff;
      pend_in      = pend_ff;
      pend_cap_in  = pend_cap_ff;
      pend_addr_in = pend_addr_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = addr_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = pend_addr_ff;
      mem_wr_data  = mem_rd_data;
      rsp_load     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = op_type'(req_operation);
               value_in   = req_value;
               removed_in = '0;
               pos_idx_in = AW'(pos_x - CMPW'(1));
               pend_in    = 1'b0;
               left_in    = CW'(cnt_x - pos_x + CMPW'(1));
               if (op_type'(req_operation) == OP_INSERT) begin
                  addr_in = AW'(cnt_x - CMPW'(1));
                  if (!ins_ok) begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end else if (full) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     status_in = ST_DONE;
                     count_in  = count_ff + CW'(1);
                     state_in  = S_SHIFT;
                  end
               end else begin
                  addr_in = AW'(pos_x - CMPW'(1));
                  if (!rem_ok) begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     status_in = ST_DONE;
                     count_in  = count_ff - CW'(1);
                     state_in  = S_SHIFT;
                  end
               end
            end
         end

         S_SHIFT: begin
            // write back the entry read last cycle, or keep it as the removed one
            if (pend_ff && !pend_cap_ff) begin
               mem_wr_en = 1'b1;
            end
            if (pend_ff && pend_cap_ff) begin
               removed_in = mem_rd_data;
            end
            // issue the next read
            if (left_ff != '0) begin
               mem_rd_en   = 1'b1;
               left_in     = left_ff - CW'(1);
               pend_in     = 1'b1;
               if (op_ff == OP_INSERT) begin
                  addr_in      = addr_ff - AW'(1);
                  pend_addr_in = addr_ff + AW'(1);
                  pend_cap_in  = 1'b0;
               end else begin
                  addr_in      = addr_ff + AW'(1);
                  pend_addr_in = addr_ff - AW'(1);
                  pend_cap_in  = (addr_ff == pos_idx_ff);
               end
            end else begin
               pend_in     = 1'b0;
               pend_cap_in = 1'b0;
               if (!pend_ff) begin
                  state_in = (op_ff == OP_INSERT) ? S_FINAL : S_DONE;
               end
            end
         end

         S_FINAL: begin
            // store the new value in the opened slot
            mem_wr_en   = 1'b1;
            mem_wr_addr = pos_idx_ff;
            mem_wr_data = value_ff;
            state_in    = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         pend_cap_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         pend_cap_ff  <= pend_cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pos_idx_ff   <= pos_idx_in;
      value_ff     <= value_in;
      status_ff    <= status_in;
      removed_ff   <= removed_in;
      addr_ff      <= addr_in;
      left_ff      <= left_in;
      pend_addr_ff <= pend_addr_in;
   end

   // result payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= removed_ff;
         rsp_count_ff   <= COUNT_W'(count_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_count         = rsp_count_ff;

   // shifting never reads and writes the same entry in one cycle
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
      else $error("ram read and write hit the same entry");

   // count stays within capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // a refused item reports no removed value
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_DONE) |-> (rsp_removed_ff == '0))
      else $error("refused item carries a removed value");

   // a finished shift with nothing in flight leaves the shift state
   a_shift_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && left_ff == '0 && !pend_ff)
         |=> (state_ff == S_FINAL || state_ff == S_DONE))
      else $error("shift did not finish");

endmodule
